[src/rpfx_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package rpfx_pkg;

  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_OFFSET = 8;

  // fixed field widths
  localparam int STR_W      = 11;
  localparam int HGT_W      = 13;
  localparam int ROW_W      = 12;
  localparam int ROW_LIMIT  = 4096;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 13;
  localparam int FAC_W      = 18;
  localparam int Q_W        = 17;

  localparam logic [CFG_IDX_W-1:0] REG_EFFECT   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STRENGTH = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 8'd3;

  localparam logic [2:0] EFF_NONE  = 3'd0;
  localparam logic [2:0] EFF_CRT   = 3'd1;
  localparam logic [2:0] EFF_SCAN  = 3'd2;
  localparam logic [2:0] EFF_BLOOM = 3'd3;
  localparam logic [2:0] EFF_ABR   = 3'd4;

  localparam logic [2:0]        RST_EFFECT   = EFF_NONE;
  localparam logic [STR_W-1:0]  RST_STRENGTH = 11'd256;
  localparam logic [HGT_W-1:0]  RST_WIDTH    = 13'd320;
  localparam logic [HGT_W-1:0]  RST_HEIGHT   = 13'd240;

  localparam logic [STR_W-1:0] CRT_SHIFT_MIN = 11'd77;
  localparam logic [FAC_W-1:0] FAC_ONE       = 18'd65536;
  // ceil(2^22 / 5): exact floor(n/5) for n < 2^22
  localparam logic [19:0]      RECIP5        = 20'd838861;
  // ceil(2^11 / 3): exact floor(n/3) for n < 2^11
  localparam logic [19:0]      RECIP3        = 20'd683;

  typedef enum logic [2:0] {
    MS_DXDX,
    MS_DYDY,
    MS_WW,
    MS_HH,
    MS_NUMS
  } mul_sel_t;

  typedef struct packed {
    logic     cfg_wr;
    logic     load;
    logic     mul_en;
    mul_sel_t msel;
    logic     num_ld;
    logic     num_add;
    logic     den_ld;
    logic     den_add;
    logic     div_init;
    logic     div_sat;
    logic     div_step;
    logic     fac_ld;
    logic     scl_ld;
    logic     ab_init;
    logic     ab_rd;
    logic     ab_dec;
    logic     out_ld;
    logic     out_ab;
    logic     adv;
  } cmd_t;

  typedef struct packed {
    logic [2:0] eff;
    logic       ab_none;
    logic       ab_end;
    logic       out_free;
  } sts_t;

endpackage
`default_nettype wire

[src/rpfx_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface rpfx_pix_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_in;
  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

interface rpfx_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_out;
  logic        last_of_run;
  modport source (output valid, output pixel_out, output last_of_run, input ready);
  modport sink   (input valid, input pixel_out, input last_of_run, output ready);
endinterface

interface rpfx_cfg_if;
  import rpfx_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[src/rpfx_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module rpfx_ctrl (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             in_valid,
  output logic            in_ready,
  input  wire             cfg_valid,
  output logic            cfg_ready,
  input  rpfx_pkg::sts_t  sts,
  output rpfx_pkg::cmd_t  cmd
);
  import rpfx_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_DPRE, ST_DSAT, ST_DIV,
    ST_FAC, ST_SCL, ST_EMIT, ST_AB0, ST_ABRD, ST_ABEM
  } state_t;

  localparam int CNT_W = $clog2(Q_W);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign cfg_ready = (state_r == ST_IDLE);
  assign in_ready  = (state_r == ST_IDLE) && !cfg_valid;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (cfg_valid) begin
          cmd.cfg_wr = 1'b1;
        end else if (in_valid) begin
          cmd.load = 1'b1;
          if (sts.eff == EFF_CRT) state_nxt = ST_M1;
          else if (sts.eff == EFF_ABR) state_nxt = ST_AB0;
          else state_nxt = ST_FAC;
        end
      end
      // vignette: dx^2 + dy^2, w^2 + h^2, num*S on the shared multiplier
      ST_M1: begin
        cmd.mul_en = 1'b1; cmd.msel = MS_DXDX; state_nxt = ST_M2;
      end
      ST_M2: begin
        cmd.num_ld = 1'b1; cmd.mul_en = 1'b1; cmd.msel = MS_DYDY; state_nxt = ST_M3;
      end
      ST_M3: begin
        cmd.num_add = 1'b1; cmd.mul_en = 1'b1; cmd.msel = MS_WW; state_nxt = ST_M4;
      end
      ST_M4: begin
        cmd.den_ld = 1'b1; cmd.mul_en = 1'b1; cmd.msel = MS_HH; state_nxt = ST_M5;
      end
      ST_M5: begin
        cmd.den_add = 1'b1; cmd.mul_en = 1'b1; cmd.msel = MS_NUMS; state_nxt = ST_DPRE;
      end
      ST_DPRE: begin
        cmd.div_init = 1'b1; state_nxt = ST_DSAT;
      end
      ST_DSAT: begin
        cmd.div_sat = 1'b1;
        cnt_nxt     = CNT_W'(Q_W - 1);
        state_nxt   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == '0) state_nxt = ST_FAC;
        else cnt_nxt = cnt_r - 1'b1;
      end
      ST_FAC: begin
        cmd.fac_ld = 1'b1; state_nxt = ST_SCL;
      end
      ST_SCL: begin
        cmd.scl_ld = 1'b1; state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.out_ld = 1'b1;
          cmd.adv    = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      ST_AB0: begin
        cmd.ab_init = 1'b1;
        if (sts.ab_none) begin
          cmd.adv   = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_ABRD;
        end
      end
      ST_ABRD: begin
        cmd.ab_rd = 1'b1; state_nxt = ST_ABEM;
      end
      ST_ABEM: begin
        if (sts.out_free) begin
          cmd.out_ld = 1'b1;
          cmd.out_ab = 1'b1;
          if (sts.ab_end) begin
            cmd.adv   = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            cmd.ab_dec = 1'b1;
            state_nxt  = ST_ABRD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

[src/rpfx_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
module rpfx_dp #(
  parameter int MAX_WIDTH  = rpfx_pkg::DEF_MAX_WIDTH,
  parameter int MAX_OFFSET = rpfx_pkg::DEF_MAX_OFFSET
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  rpfx_pkg::cmd_t                   cmd,
  output rpfx_pkg::sts_t                   sts,
  input  wire [rpfx_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire [rpfx_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire [31:0]                       pixel_in,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [31:0]                      pixel_out,
  output logic                             last_of_run
);
  import rpfx_pkg::*;

  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int XW   = $clog2(MAX_WIDTH);
  localparam int CW   = (WW > HGT_W) ? WW : HGT_W;
  localparam int NW   = 2 * CW + 1;
  localparam int PRW  = NW + CW;
  localparam int DIVW = NW + STR_W + 7;
  localparam int WD   = 2 * MAX_OFFSET + 1;
  localparam int AW   = $clog2(WD);
  localparam int OW   = $clog2(MAX_OFFSET + 1);

  // configuration
  logic [2:0]       eff_r;
  logic [STR_W-1:0] str_r;
  logic [HGT_W-1:0] fw_r, fh_r;

  // position and row state
  logic [XW-1:0]    x_r;
  logic [ROW_W-1:0] y_r;
  logic [AW-1:0]    wp_r;
  logic [7:0]       prev_r;

  // payload
  logic [31:0]      px_r;
  logic [PRW-1:0]   prod_r;
  logic [NW-1:0]    num_r, den_r;
  logic [DIVW-1:0]  rem_r, ds_r;
  logic [Q_W-1:0]   q_r;
  logic             sat_r;
  logic [FAC_W-1:0] fac_r;
  logic [31:0]      res_r;
  logic [7:0]       vr_r;
  logic [AW-1:0]    d_r, dend_r;
  logic [31:0]      rd_c_r, rd_red_r;
  logic [31:0]      win_r [WD];
  logic             out_valid_r;
  logic [31:0]      out_pix_r;
  logic             out_last_r;

  logic [WW-1:0]    w;
  logic [HGT_W-1:0] h;
  logic             last_col, cfg_hit;
  logic [CW-1:0]    dx, dy;
  logic [NW-1:0]    ma;
  logic [CW-1:0]    mb;
  logic [39:0]      scan_p, bloom_p;
  logic [19:0]      bloom_n;
  logic [17:0]      scan_dec, bloom_dec, up_t;
  logic [FAC_W-1:0] scan_f, bloom_f, fac_nxt;
  logic [9:0]       up, lsum;
  logic [7:0]       thr;
  logic [19:0]      lum_p;
  logic [8:0]       lum;
  logic [7:0]       vr, outr;
  logic [4:0]       off_raw;
  logic [OW-1:0]    off;
  logic             x_ge_off;
  logic [31:0]      dr_sum, dr_d;
  logic [AW-1:0]    addr_c, addr_red;

  function automatic logic [7:0] scale_c(input logic [7:0] c, input logic [FAC_W-1:0] f);
    logic [FAC_W+7:0] p;
    p = (FAC_W+8)'(c) * (FAC_W+8)'(f);
    if (p[FAC_W+7:16] > 10'd255) return 8'hFF;
    return p[23:16];
  endfunction

  // ring slot of the pixel d columns back from the current one
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] wp, input logic [31:0] d);
    logic [31:0] t;
    t = (32'(wp) >= d) ? 32'(wp) - d : 32'(wp) + 32'(WD) - d;
    return AW'(t);
  endfunction

  always_comb begin
    if (fw_r == '0) w = WW'(1);
    else if (32'(fw_r) > 32'(MAX_WIDTH)) w = WW'(MAX_WIDTH);
    else w = WW'(fw_r);
    if (fh_r == '0) h = HGT_W'(1);
    else if (32'(fh_r) > 32'(ROW_LIMIT)) h = HGT_W'(ROW_LIMIT);
    else h = fh_r;
  end

  assign last_col = (32'(x_r) + 32'd1) >= 32'(w);
  assign cfg_hit  = cmd.cfg_wr && (cfg_index <= REG_HEIGHT);

  // |2x - w| and |2y - h|
  always_comb begin
    logic [CW:0] a, b;
    a  = (CW+1)'({x_r, 1'b0});
    b  = (CW+1)'(w);
    dx = CW'((a >= b) ? a - b : b - a);
    a  = (CW+1)'({y_r, 1'b0});
    b  = (CW+1)'(h);
    dy = CW'((a >= b) ? a - b : b - a);
  end

  always_comb begin
    case (cmd.msel)
      MS_DXDX: begin ma = NW'(dx); mb = dx; end
      MS_DYDY: begin ma = NW'(dy); mb = dy; end
      MS_WW:   begin ma = NW'(w);  mb = CW'(w); end
      MS_HH:   begin ma = NW'(h);  mb = CW'(h); end
      MS_NUMS: begin ma = num_r;   mb = CW'(str_r); end
      default: begin ma = '0;      mb = '0; end
    endcase
  end

  // strength-derived factors
  always_comb begin
    scan_p    = 40'({str_r, 9'b0}) * 40'(RECIP5);
    scan_dec  = scan_p[39:22];
    scan_f    = (scan_dec >= FAC_ONE) ? '0 : FAC_ONE - scan_dec;
    bloom_n   = 20'(str_r) * 20'd384;
    bloom_p   = 40'(bloom_n) * 40'(RECIP5);
    bloom_dec = bloom_p[39:22];
    bloom_f   = FAC_ONE + bloom_dec;
    up_t      = 18'(str_r) * 18'd100 + 18'd255;
    up        = up_t[17:8];
    thr       = (up > 10'd100) ? 8'd100 : 8'(10'd200 - up);
    lsum      = 10'(px_r[31:24]) + 10'(px_r[23:16]) + 10'(px_r[15:8]);
    lum_p     = 20'(lsum) * RECIP3;
    lum       = lum_p[19:11];
    case (eff_r)
      EFF_CRT:   fac_nxt = (sat_r || q_r[Q_W-1]) ? '0 : FAC_ONE - FAC_W'(q_r);
      EFF_SCAN:  fac_nxt = y_r[0] ? FAC_ONE : scan_f;
      EFF_BLOOM: fac_nxt = (lum > 9'(thr)) ? bloom_f : FAC_ONE;
      default:   fac_nxt = FAC_ONE;
    endcase
  end

  assign vr   = scale_c(px_r[31:24], fac_r);
  assign outr = (eff_r == EFF_CRT && str_r >= CRT_SHIFT_MIN && x_r != '0) ? prev_r : vr;

  // aberration: blue always comes from the newest pixel of the row
  always_comb begin
    off_raw = 5'((12'(str_r) + 12'd64) >> 7);
    if (off_raw == '0) off = OW'(1);
    else if (32'(off_raw) > 32'(MAX_OFFSET)) off = OW'(MAX_OFFSET);
    else off = OW'(off_raw);
    x_ge_off = 32'(x_r) >= 32'(off);
    dr_sum   = 32'(d_r) + 32'(off);
    dr_d     = (dr_sum > 32'(x_r)) ? 32'(x_r) : dr_sum;
    addr_c   = slot_of(wp_r, 32'(d_r));
    addr_red = slot_of(wp_r, dr_d);
  end

  assign sts.eff      = eff_r;
  assign sts.ab_none  = !last_col && !x_ge_off;
  assign sts.ab_end   = (d_r == dend_r);
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid   = out_valid_r;
  assign pixel_out   = out_pix_r;
  assign last_of_run = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_r       <= RST_EFFECT;
      str_r       <= RST_STRENGTH;
      fw_r        <= RST_WIDTH;
      fh_r        <= RST_HEIGHT;
      x_r         <= '0;
      y_r         <= '0;
      wp_r        <= '0;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_hit) begin
        unique case (cfg_index)
          REG_EFFECT:   eff_r <= cfg_data[2:0];
          REG_STRENGTH: str_r <= cfg_data[STR_W-1:0];
          REG_WIDTH:    fw_r  <= cfg_data;
          REG_HEIGHT:   fh_r  <= cfg_data;
          default: ;
        endcase
        x_r    <= '0;
        y_r    <= '0;
        wp_r   <= '0;
        prev_r <= '0;
      end else if (cmd.adv) begin
        if (last_col) begin
          x_r    <= '0;
          wp_r   <= '0;
          prev_r <= '0;
          y_r    <= (32'(y_r) + 32'd1 >= 32'(h)) ? '0 : y_r + 1'b1;
        end else begin
          x_r    <= x_r + 1'b1;
          wp_r   <= (32'(wp_r) == WD - 1) ? '0 : wp_r + 1'b1;
          prev_r <= vr_r;
        end
      end
      if (cmd.out_ld) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px_r       <= pixel_in;
      win_r[wp_r] <= pixel_in;
    end
    if (cmd.mul_en) prod_r <= PRW'(ma) * PRW'(mb);
    if (cmd.num_ld)  num_r <= NW'(prod_r);
    if (cmd.num_add) num_r <= num_r + NW'(prod_r);
    if (cmd.den_ld)  den_r <= NW'(prod_r);
    if (cmd.den_add) den_r <= den_r + NW'(prod_r);
    if (cmd.div_init) begin
      rem_r <= DIVW'(prod_r[NW+STR_W-1:0]) << 7;
      ds_r  <= DIVW'(den_r) << (Q_W - 1);
      q_r   <= '0;
    end
    // quotient of 2^17 or more saturates the vignette to black
    if (cmd.div_sat) sat_r <= rem_r >= (ds_r << 1);
    if (cmd.div_step) begin
      if (rem_r >= ds_r) begin
        rem_r <= rem_r - ds_r;
        q_r   <= {q_r[Q_W-2:0], 1'b1};
      end else begin
        q_r   <= {q_r[Q_W-2:0], 1'b0};
      end
      ds_r <= ds_r >> 1;
    end
    if (cmd.fac_ld) fac_r <= fac_nxt;
    if (cmd.scl_ld) begin
      vr_r  <= vr;
      res_r <= {outr, scale_c(px_r[23:16], fac_r), scale_c(px_r[15:8], fac_r), px_r[7:0]};
    end
    if (cmd.ab_init) begin
      d_r    <= last_col ? (x_ge_off ? AW'(off) : AW'(x_r)) : AW'(off);
      dend_r <= last_col ? '0 : AW'(off);
    end
    if (cmd.ab_dec) d_r <= d_r - 1'b1;
    if (cmd.ab_rd) begin
      rd_c_r   <= win_r[addr_c];
      rd_red_r <= win_r[addr_red];
    end
    if (cmd.out_ld) begin
      if (cmd.out_ab) begin
        out_pix_r  <= {rd_red_r[31:24], rd_c_r[23:16], px_r[15:8], rd_c_r[7:0]};
        out_last_r <= (d_r == dend_r);
      end else begin
        out_pix_r  <= res_r;
        out_last_r <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

[src/retro_pixel_postfx_pass.sv]
`timescale 1ns / 1ps
`default_nettype none
// channel   dir  handshake      payload
// in_pix    in   valid/ready    pixel_in[31:0]
// out_res   out  valid/ready    pixel_out[31:0], last_of_run
// cfg_wr    in   valid/ready    index[7:0], data[12:0]
//
// One pixel at a time. Pass-through, scanlines, bloom: factor, scale, then emit.
// CRT: five passes over the shared multiplier and a 17-step restoring
// divide for the vignette factor come before factor, scale and emit.
// Aberration: a start step, then a window read and an emit per result word.
// Output word held in a register until taken; reset is synchronous, active low.
module retro_pixel_postfx_pass #(
  parameter int MAX_WIDTH  = rpfx_pkg::DEF_MAX_WIDTH,
  parameter int MAX_OFFSET = rpfx_pkg::DEF_MAX_OFFSET
) (
  input  wire                clk,
  input  wire                rst_n,
  rpfx_pix_if.sink           in_pix,
  rpfx_res_if.source         out_res,
  rpfx_cfg_if.sink           cfg_wr
);
  import rpfx_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_rdy, cfg_rdy;

  assign in_pix.ready = in_rdy;
  assign cfg_wr.ready = cfg_rdy;

  rpfx_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_pix.valid),
    .in_ready  (in_rdy),
    .cfg_valid (cfg_wr.valid),
    .cfg_ready (cfg_rdy),
    .sts       (sts),
    .cmd       (cmd)
  );

  rpfx_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_OFFSET (MAX_OFFSET)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_index   (cfg_wr.index),
    .cfg_data    (cfg_wr.data),
    .pixel_in    (in_pix.pixel_in),
    .out_valid   (out_res.valid),
    .out_ready   (out_res.ready),
    .pixel_out   (out_res.pixel_out),
    .last_of_run (out_res.last_of_run)
  );

endmodule
`default_nettype wire

[src/rpfx_chk.sv]
`timescale 1ns / 1ps
`default_nettype none
module rpfx_chk (
  input wire        clk,
  input wire        rst_n,
  input wire        in_valid,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire [31:0] out_pixel,
  input wire        out_last,
  input wire        cfg_valid,
  input wire        cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel) && $stable(out_last))
    else $error("result word changed while stalled");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken on two consecutive cycles");

  a_cfg_vs_pix: assert property (@(posedge clk) disable iff (!rst_n)
    !(cfg_valid && cfg_ready && in_valid && in_ready))
    else $error("config write and pixel taken together");

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind retro_pixel_postfx_pass rpfx_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_pix.valid),
  .in_ready  (in_pix.ready),
  .out_valid (out_res.valid),
  .out_ready (out_res.ready),
  .out_pixel (out_res.pixel_out),
  .out_last  (out_res.last_of_run),
  .cfg_valid (cfg_wr.valid),
  .cfg_ready (cfg_wr.ready)
);
`default_nettype wire

[test/rpfx_tb_if.sv]
`timescale 1ns / 1ps
// Channel interfaces (rpfx_pix_if, rpfx_res_if, rpfx_cfg_if) come from src/rpfx_if.sv;
// this file only keeps the testbench-side constants shared by the top.
package rpfx_tb_pkg;
  localparam int WIN_DEPTH = 17;
  localparam int TB_MAX_OFFSET = 8;
  localparam int TB_MAX_WIDTH = 4096;
endpackage

[test/tb_retro_pixel_postfx_pass.sv]
`timescale 1ns / 1ps
module tb_retro_pixel_postfx_pass;
  import rpfx_pkg::*;
  import rpfx_tb_pkg::*;

  typedef struct packed {
    logic [31:0] pixel;
    logic        last;
  } word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rpfx_pix_if in_pix();
  rpfx_res_if out_res();
  rpfx_cfg_if cfg_wr();

  retro_pixel_postfx_pass DUT (
    .clk(clk), .rst_n(rst_n), .in_pix(in_pix), .out_res(out_res), .cfg_wr(cfg_wr)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  logic [2:0]  m_eff;
  logic [10:0] m_str;
  logic [12:0] m_wid, m_hgt;
  int unsigned col, row, prev_red;
  logic [31:0] window [WIN_DEPTH];

  word_t expected_words[$];
  int errors = 0;
  int shown = 0;
  int idle_cycles = 0;
  int hold_off = 0;
  bit rand_stall = 1'b1;

  function automatic int unsigned eff_w();
    int unsigned w;
    w = m_wid;
    if (w < 1) w = 1;
    if (w > TB_MAX_WIDTH) w = TB_MAX_WIDTH;
    return w;
  endfunction

  function automatic int unsigned eff_h();
    int unsigned h;
    h = m_hgt;
    if (h < 1) h = 1;
    if (h > 4096) h = 4096;
    return h;
  endfunction

  function automatic logic [7:0] scale_ch(logic [7:0] c, longint unsigned f);
    longint unsigned v;
    v = (longint'(c) * f) >> 16;
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  function automatic logic [31:0] scale_px(logic [31:0] p, longint unsigned f);
    return {scale_ch(p[31:24], f), scale_ch(p[23:16], f), scale_ch(p[15:8], f), p[7:0]};
  endfunction

  function automatic logic [31:0] aberr_px(int unsigned ox, int unsigned off, int unsigned w);
    int unsigned rx, bx;
    logic [31:0] c;
    rx = (ox >= off) ? ox - off : 0;
    bx = ox + off;
    if (bx > w - 1) bx = w - 1;
    c = window[ox % WIN_DEPTH];
    return {window[rx % WIN_DEPTH][31:24], c[23:16], window[bx % WIN_DEPTH][15:8], c[7:0]};
  endfunction

  function automatic void restart_frame();
    col = 0;
    row = 0;
    prev_red = 0;
    for (int i = 0; i < WIN_DEPTH; i++) window[i] = '0;
  endfunction

  // expected words for one pixel, pushed onto expected_words
  function automatic void predict_pixel(logic [31:0] px);
    int unsigned w, h, x, y, off, ox;
    longint unsigned s, dx, dy, num, den, sub, v, f, up, thr, lum;
    logic [31:0] res[$];
    logic [7:0] vr, outr;
    w = eff_w();
    h = eff_h();
    x = col;
    y = row;
    s = m_str;
    case (m_eff)
      EFF_CRT: begin
        dx = (2 * x >= w) ? 2 * x - w : w - 2 * x;
        dy = (2 * y >= h) ? 2 * y - h : h - 2 * y;
        num = dx * dx + dy * dy;
        den = longint'(w) * w + longint'(h) * h;
        sub = num * s * 128 / den;
        v = (sub >= 65536) ? 0 : 65536 - sub;
        vr = scale_ch(px[31:24], v);
        outr = (s >= 77 && x >= 1) ? prev_red[7:0] : vr;
        prev_red = vr;
        res.push_back({outr, scale_ch(px[23:16], v), scale_ch(px[15:8], v), px[7:0]});
      end
      EFF_SCAN: begin
        if (y[0] == 1'b0) begin
          f = s * 512 / 5;
          f = (f >= 65536) ? 0 : 65536 - f;
          px = scale_px(px, f);
        end
        res.push_back(px);
      end
      EFF_BLOOM: begin
        up = (s * 100 + 255) / 256;
        thr = (up > 100) ? 100 : 200 - up;
        lum = (px[31:24] + px[23:16] + px[15:8]) / 3;
        if (lum > thr) px = scale_px(px, 65536 + s * 384 / 5);
        res.push_back(px);
      end
      EFF_ABR: begin
        off = (s + 64) >> 7;
        if (off < 1) off = 1;
        if (off > TB_MAX_OFFSET) off = TB_MAX_OFFSET;
        window[x % WIN_DEPTH] = px;
        if (x >= off) res.push_back(aberr_px(x - off, off, w));
        if (x >= w - 1) begin
          for (ox = (w > off) ? w - off : 0; ox < w; ox++) res.push_back(aberr_px(ox, off, w));
        end
      end
      default: res.push_back(px);
    endcase
    if (x + 1 >= w) begin
      col = 0;
      prev_red = 0;
      row = (y + 1 >= h) ? 0 : y + 1;
    end else begin
      col = x + 1;
    end
    foreach (res[k]) expected_words.push_back('{pixel: res[k], last: (k == res.size() - 1)});
  endfunction

  // watchdog: cycles with no word moving anywhere
  always @(posedge clk) begin
    if ((in_pix.valid && in_pix.ready) || (out_res.valid && out_res.ready) ||
        (cfg_wr.valid && cfg_wr.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result side: random wait after each word, long hold-off on request
  initial begin
    int gap;
    out_res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off > 0) begin
        out_res.ready <= 1'b0;
        hold_off <= hold_off - 1;
      end else if (out_res.ready && out_res.valid) begin
        gap = rand_stall ? $urandom_range(0, 17) : 0;
        if (gap > 0) begin
          out_res.ready <= 1'b0;
          repeat (gap) @(posedge clk);
          out_res.ready <= 1'b1;
        end
      end else begin
        out_res.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    word_t exp_w;
    if (rst_n && out_res.valid && out_res.ready) begin
      if (expected_words.size() == 0) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("unexpected word %h last=%b", out_res.pixel_out, out_res.last_of_run);
        end
      end else begin
        exp_w = expected_words.pop_front();
        if (exp_w.pixel !== out_res.pixel_out || exp_w.last !== out_res.last_of_run) begin
          errors++;
          if (shown < 10) begin
            shown++;
            $display("mismatch: exp %h/%b got %h/%b", exp_w.pixel, exp_w.last,
                     out_res.pixel_out, out_res.last_of_run);
          end
        end
      end
    end
  end

  // valid stays up after a take when the next word follows at once
  task automatic send_pixel(logic [31:0] px, bit use_gap = 1'b1);
    int gap;
    gap = use_gap ? $urandom_range(0, 17) : 0;
    if ($urandom_range(0, 2) == 0) gap = 0;
    if (gap > 0) begin
      in_pix.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_pix.valid <= 1'b1;
    in_pix.pixel_in <= px;
    @(posedge clk);
    while (!in_pix.ready) @(posedge clk);
    predict_pixel(px);
  endtask

  task automatic drain();
    in_pix.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    // a pixel that yields no word may still be in progress
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [12:0] val);
    cfg_wr.valid <= 1'b1;
    cfg_wr.index <= idx;
    cfg_wr.data <= val;
    @(posedge clk);
    while (!cfg_wr.ready) @(posedge clk);
    cfg_wr.valid <= 1'b0;
    case (idx)
      REG_EFFECT: m_eff = val[2:0];
      REG_STRENGTH: m_str = val[10:0];
      REG_WIDTH: m_wid = val;
      REG_HEIGHT: m_hgt = val;
      default: ;
    endcase
    if (idx <= REG_HEIGHT) restart_frame();
    @(posedge clk);
  endtask

  task automatic setup(logic [2:0] e, logic [10:0] s, logic [12:0] w, logic [12:0] h);
    drain();
    write_reg(REG_EFFECT, e);
    write_reg(REG_STRENGTH, s);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
  endtask

  function automatic logic [31:0] rand_px();
    case ($urandom_range(0, 5))
      0: return 32'hFFFFFFFF;
      1: return 32'h00000000;
      2: return {8'($urandom_range(200, 255)), 8'($urandom_range(200, 255)),
                 8'($urandom_range(200, 255)), 8'($urandom_range(0, 255))};
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    // defaults after reset: pass-through
    send_pixel(32'h00000000);
    send_pixel(32'hFFFFFFFF);
    send_pixel(32'hA5A5A5A5);
    send_pixel(32'h5A5A5A5A);
    setup(EFF_SCAN, 11'd1024, 13'd2, 13'd2);
    repeat (4) send_pixel(32'hFFFFFF80);
    setup(EFF_BLOOM, 11'd1024, 13'd3, 13'd1);
    send_pixel(32'hFFFFFF01);
    send_pixel(32'h64646400);
    send_pixel(32'hC8C9C8FF);
    setup(EFF_CRT, 11'd77, 13'd4, 13'd2);
    repeat (8) send_pixel(rand_px());
    setup(EFF_ABR, 11'd2047, 13'd5, 13'd1);
    repeat (5) send_pixel(rand_px());
    setup(EFF_ABR, 11'd0, 13'd1, 13'd0);
    repeat (2) send_pixel(rand_px());
    setup(3'd7, 11'd0, 13'd0, 13'd8191);
    send_pixel(32'h12345678);
    drain();
    write_reg(8'd200, 13'h1FFF);  // ignored index
    send_pixel(32'h87654321);
  endtask

  task automatic test_random();
    logic [2:0] e;
    int n;
    n = 0;
    while (n < 60) begin
      e = $urandom_range(0, 7);
      setup(e, ($urandom_range(0, 3) == 0) ? 11'd1024 : 11'($urandom_range(0, 2047)),
            13'($urandom_range(1, 20)), 13'($urandom_range(1, 4)));
      repeat ($urandom_range(5, 25)) begin
        send_pixel(rand_px());
        n++;
      end
    end
  endtask

  task automatic test_backpressure();
    setup(EFF_ABR, 11'd1024, 13'd12, 13'd2);
    hold_off = 300;
    repeat (24) send_pixel(rand_px(), 1'b0);
    // sender waits for every word before going on
    drain();
    rand_stall = 1'b0;
    setup(EFF_BLOOM, 11'd512, 13'd6, 13'd2);
    repeat (12) send_pixel(rand_px(), 1'b0);
    rand_stall = 1'b1;
  endtask

  initial begin
    in_pix.valid <= 1'b0;
    in_pix.pixel_in <= '0;
    cfg_wr.valid <= 1'b0;
    cfg_wr.index <= '0;
    cfg_wr.data <= '0;
    m_eff = RST_EFFECT;
    m_str = RST_STRENGTH;
    m_wid = RST_WIDTH;
    m_hgt = RST_HEIGHT;
    restart_frame();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random();
    drain();
    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end
endmodule
